>>> rtl/core/lr_pkg.sv
// lr_pkg: shared constants and controller/datapath interface types for
// the line rasterizer core. No dependencies.
`default_nettype none

package lr_pkg;

  // default grid coordinate width (grid is 2**COORD_BITS square)
  localparam int unsigned CoordBitsDefault = 6;

  // fixed width of every coordinate field on the stream ports
  localparam int unsigned FieldBits = 6;

  // stream payload widths
  localparam int unsigned InDataBits  = 4 * FieldBits;
  localparam int unsigned OutDataBits = 16;

  // commands from controller to datapath
  typedef struct packed {
    logic load;  // capture endpoints and set up the line
    logic step;  // advance one pixel along the major axis
  } lr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic last;  // current pixel is the final one of the line
  } lr_status_t;

endpackage : lr_pkg

`default_nettype wire

>>> rtl/core/lr_ctrl.sv
// lr_ctrl: line rasterizer controller state machine, drives the stream
// handshakes and issues load/step commands. Depends on lr_pkg.
`default_nettype none

module lr_ctrl import lr_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire lr_status_t status_i,
  output lr_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } lr_state_e;

  lr_state_e state_q, state_d;
  logic      out_xfer;

  // output transfer happens only while a line is running
  assign out_xfer = (state_q == ST_RUN) && out_ready_i;

  // handshakes and commands
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o  = 1'b1;
      ST_RUN:  out_valid_o = 1'b1;
      default: ;
    endcase
    cmd_o.load = in_ready_o && in_valid_i;
    cmd_o.step = out_xfer && !status_i.last;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_RUN;
      ST_RUN:  if (out_xfer && status_i.last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : lr_ctrl

`default_nettype wire

>>> rtl/core/lr_datapath.sv
// lr_datapath: line setup (deltas, axis, ordering) and the Bresenham
// stepping registers of the line rasterizer. Depends on lr_pkg.
`default_nettype none

module lr_datapath import lr_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lr_cmd_t              cmd_i,
  input  wire logic [FieldBits-1:0] x_start_i,
  input  wire logic [FieldBits-1:0] y_start_i,
  input  wire logic [FieldBits-1:0] x_end_i,
  input  wire logic [FieldBits-1:0] y_end_i,
  output logic      [FieldBits-1:0] pixel_x_o,
  output logic      [FieldBits-1:0] pixel_y_o,
  output lr_status_t                status_o
);

  // error term spans about -2*major..2*major plus sign
  localparam int unsigned ErrBits = CoordBits + 3;

  typedef logic [CoordBits-1:0]      coord_t;
  typedef logic signed [ErrBits-1:0] err_t;

  coord_t ax, ay, bx, by, dx, dy;
  coord_t mj0, mn0, mj1, mn1;
  coord_t mj_lo, mn_lo, mn_hi;
  coord_t mj_d_delta, mn_d_delta;
  logic   y_major, swap;

  coord_t mj_q, mj_d, mn_q, mn_d;
  coord_t steps_q, steps_d;
  coord_t major_delta_q, minor_delta_q;
  logic   y_major_q, down_q;
  err_t   err_q, err_d;
  err_t   inc_diag, inc_flat;

  // mask coordinates to the grid
  assign ax = x_start_i[CoordBits-1:0];
  assign ay = y_start_i[CoordBits-1:0];
  assign bx = x_end_i[CoordBits-1:0];
  assign by = y_end_i[CoordBits-1:0];

  // line setup: deltas, major axis, endpoint ordering
  always_comb begin
    dx      = (ax > bx) ? ax - bx : bx - ax;
    dy      = (ay > by) ? ay - by : by - ay;
    y_major = dy > dx;
    mj0     = y_major ? ay : ax;
    mn0     = y_major ? ax : ay;
    mj1     = y_major ? by : bx;
    mn1     = y_major ? bx : by;
    mj_d_delta = y_major ? dy : dx;
    mn_d_delta = y_major ? dx : dy;
    swap    = mj0 > mj1;
    mj_lo   = swap ? mj1 : mj0;
    mn_lo   = swap ? mn1 : mn0;
    mn_hi   = swap ? mn0 : mn1;
  end

  // error increments for the stored deltas
  assign inc_flat = err_t'({minor_delta_q, 1'b0});
  assign inc_diag = err_t'({minor_delta_q, 1'b0}) - err_t'({major_delta_q, 1'b0});

  // stepping
  always_comb begin
    mj_d    = mj_q;
    mn_d    = mn_q;
    err_d   = err_q;
    steps_d = steps_q;
    if (cmd_i.load) begin
      mj_d    = mj_lo;
      mn_d    = mn_lo;
      err_d   = err_t'({mn_d_delta, 1'b0}) - err_t'(mj_d_delta);
      steps_d = mj_d_delta;
    end else if (cmd_i.step) begin
      mj_d    = mj_q + coord_t'(1);
      steps_d = steps_q - coord_t'(1);
      if (err_q > err_t'(0)) begin
        mn_d  = down_q ? mn_q - coord_t'(1) : mn_q + coord_t'(1);
        err_d = err_q + inc_diag;
      end else begin
        err_d = err_q + inc_flat;
      end
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mj_q          <= '0;
      mn_q          <= '0;
      err_q         <= '0;
      steps_q       <= '0;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      y_major_q     <= 1'b0;
      down_q        <= 1'b0;
    end else begin
      mj_q    <= mj_d;
      mn_q    <= mn_d;
      err_q   <= err_d;
      steps_q <= steps_d;
      if (cmd_i.load) begin
        major_delta_q <= mj_d_delta;
        minor_delta_q <= mn_d_delta;
        y_major_q     <= y_major;
        down_q        <= mn_hi < mn_lo;
      end
    end
  end

  // current pixel back in x/y order
  assign pixel_x_o     = FieldBits'(y_major_q ? mn_q : mj_q);
  assign pixel_y_o     = FieldBits'(y_major_q ? mj_q : mn_q);
  assign status_o.last = steps_q == '0;

endmodule : lr_datapath

`default_nettype wire

>>> rtl/core/line_rasterizer_core.sv
// line_rasterizer_core: top level of the Bresenham line rasterizer.
// Instantiates lr_ctrl and lr_datapath; depends on lr_pkg.
`default_nettype none

// Takes one line segment per input transfer (two endpoints on a grid of
// 2**COORD_BITS by 2**COORD_BITS pixels; coordinate bits above COORD_BITS
// are ignored) and emits its pixels one per output transfer, from the
// endpoint with the lower major coordinate, with tlast on the final pixel.
// A line is set up when its segment is accepted and then yields
// max(|dx|,|dy|) + 1 pixels, so at most 2**COORD_BITS pixels; the
// single stepping register set of the datapath holds one line at a time,
// and a new segment is taken once the last pixel has been transferred.

module line_rasterizer_core import lr_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // x_start[5:0], y_start[11:6], x_end[17:12], y_end[23:18]
  input  wire logic [InDataBits-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // pixel_x[5:0], pixel_y[11:6], zero[15:12]
  output logic      [OutDataBits-1:0] m_axis_tdata_o,
  // last_pixel
  output logic                        m_axis_tlast_o
);

  lr_cmd_t              cmd;
  lr_status_t           status;
  logic [FieldBits-1:0] pixel_x, pixel_y;

  // controller
  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  lr_datapath #(
    .CoordBits (COORD_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .x_start_i (s_axis_tdata_i[FieldBits-1:0]),
    .y_start_i (s_axis_tdata_i[2*FieldBits-1:FieldBits]),
    .x_end_i   (s_axis_tdata_i[3*FieldBits-1:2*FieldBits]),
    .y_end_i   (s_axis_tdata_i[4*FieldBits-1:3*FieldBits]),
    .pixel_x_o (pixel_x),
    .pixel_y_o (pixel_y),
    .status_o  (status)
  );

  // output packing
  assign m_axis_tdata_o = OutDataBits'({pixel_y, pixel_x});
  assign m_axis_tlast_o = status.last;

endmodule : line_rasterizer_core

`default_nettype wire

>>> verif/line_rasterizer_core_tb.sv
// line_rasterizer_core_tb: self-checking stream testbench for the line rasterizer core.
// Predicts every pixel of each segment in a local Bresenham tracer; needs lr_pkg and the RTL.
`timescale 1ns / 100ps

module line_rasterizer_core_tb;
  import lr_pkg::*;

  localparam int unsigned CoordBits   = CoordBitsDefault;
  localparam int          DirectedCnt = 22;
  localparam int          RandomCnt   = 450;
  localparam int          TotalCnt    = DirectedCnt + RandomCnt;
  localparam int          HoldCycles  = 400;
  localparam int          TailCycles  = 80;

  typedef struct packed {
    logic [FieldBits-1:0] x;
    logic [FieldBits-1:0] y;
    logic                 last;
  } pixel_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OutDataBits-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  logic [InDataBits-1:0] segment_q[$];
  pixel_t                pixel_q[$];
  int                    seg_taken;
  int                    error_cnt;
  logic                  rx_hold;
  logic                  in_xfer_q;

  line_rasterizer_core #(.COORD_BITS(CoordBits)) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [InDataBits-1:0] make_segment(int ax, int ay, int bx, int by);
    return {by[FieldBits-1:0], bx[FieldBits-1:0], ay[FieldBits-1:0], ax[FieldBits-1:0]};
  endfunction

  // append one segment to the pending queue
  function automatic void queue_segment(int ax, int ay, int bx, int by);
    segment_q.insert(segment_q.size(), make_segment(ax, ay, bx, by));
  endfunction

  // bresenham tracer: queue every pixel the segment should produce
  function automatic void trace_segment(logic [InDataBits-1:0] seg);
    int     grid_mask;
    int     ax, ay, bx, by, dx, dy;
    int     mj0, mn0, mj1, mn1, tmp;
    int     err, steps, cnt;
    bit     y_major, down;
    pixel_t pix;
    grid_mask = (1 << CoordBits) - 1;
    ax = int'(seg[5:0]) & grid_mask;
    ay = int'(seg[11:6]) & grid_mask;
    bx = int'(seg[17:12]) & grid_mask;
    by = int'(seg[23:18]) & grid_mask;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    y_major = dy > dx;
    if (y_major) begin
      mj0 = ay; mn0 = ax; mj1 = by; mn1 = bx;
      tmp = dx; dx = dy; dy = tmp;
    end else begin
      mj0 = ax; mn0 = ay; mj1 = bx; mn1 = by;
    end
    // walk from the lower major coordinate
    if (mj0 > mj1) begin
      tmp = mj0; mj0 = mj1; mj1 = tmp;
      tmp = mn0; mn0 = mn1; mn1 = tmp;
    end
    down  = mn1 < mn0;
    err   = 2 * dy - dx;
    steps = dx;
    cnt   = 0;
    forever begin
      pix.x    = y_major ? mn0[FieldBits-1:0] : mj0[FieldBits-1:0];
      pix.y    = y_major ? mj0[FieldBits-1:0] : mn0[FieldBits-1:0];
      pix.last = (steps == 0);
      pixel_q.insert(pixel_q.size(), pix);
      cnt++;
      if (steps == 0 || cnt >= (1 << CoordBits)) break;
      steps--;
      mj0 = (mj0 + 1) & grid_mask;
      if (err > 0) begin
        mn0 = (down ? mn0 - 1 : mn0 + 1) & grid_mask;
        err += 2 * (dy - dx);
      end else begin
        err += 2 * dy;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_cnt++;
  endtask

  // idle rates per phase, in percent
  function automatic int tx_idle_pct();
    if (seg_taken < TotalCnt / 3) return 7;
    if (seg_taken < 2 * TotalCnt / 3) return 65;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (seg_taken < TotalCnt / 3) return 65;
    if (seg_taken < 2 * TotalCnt / 3) return 7;
    return 0;
  endfunction

  // input side: note each accepted segment and predict its pixels
  always @(posedge clk_i) begin
    in_xfer_q <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      trace_segment(s_axis_tdata);
      void'(segment_q.pop_front());
      seg_taken <= seg_taken + 1;
    end
  end

  // driver: offer the next pending segment at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_xfer_q) begin
      if (segment_q.size() > 0 && $urandom_range(99) >= tx_idle_pct()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= segment_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with random stalls and the long hold-off
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !rx_hold && ($urandom_range(99) >= rx_idle_pct());
  end

  // monitor: compare each pixel transfer with the oldest prediction
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("unexpected pixel x", int'(m_axis_tdata[5:0]), -1);
      end else begin
        want = pixel_q.pop_front();
        if (m_axis_tdata[5:0] !== want.x)
          report_mismatch("pixel_x", int'(m_axis_tdata[5:0]), int'(want.x));
        if (m_axis_tdata[11:6] !== want.y)
          report_mismatch("pixel_y", int'(m_axis_tdata[11:6]), int'(want.y));
        if (m_axis_tlast !== want.last)
          report_mismatch("last_pixel", int'(m_axis_tlast), int'(want.last));
        if (m_axis_tdata[15:12] !== 4'b0)
          report_mismatch("tdata padding", int'(m_axis_tdata[15:12]), 0);
      end
    end
  end

  // long receiver hold-off so the core backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (seg_taken >= TotalCnt - 60);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL line_rasterizer_core");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int ax, ay, bx, by, mode, len;
    seg_taken = 0;
    error_cnt = 0;
    // single points, at both grid corners
    queue_segment(0, 0, 0, 0);
    queue_segment(63, 63, 63, 63);
    // horizontal and vertical, both orders
    queue_segment(0, 17, 63, 17);
    queue_segment(63, 40, 0, 40);
    queue_segment(5, 0, 5, 63);
    queue_segment(58, 63, 58, 0);
    // equal deltas pick x as major, minor going up and down
    queue_segment(0, 0, 63, 63);
    queue_segment(63, 0, 0, 63);
    queue_segment(10, 20, 13, 17);
    // shallow lines, minor stepping up and down
    queue_segment(0, 0, 63, 1);
    queue_segment(2, 30, 50, 11);
    queue_segment(61, 3, 4, 29);
    // steep lines, minor stepping up and down
    queue_segment(0, 0, 1, 63);
    queue_segment(40, 2, 21, 60);
    queue_segment(9, 62, 33, 1);
    // two-pixel lines
    queue_segment(31, 31, 32, 31);
    queue_segment(31, 31, 31, 30);
    queue_segment(20, 20, 21, 21);
    // alternating bit patterns
    queue_segment(42, 21, 21, 42);
    queue_segment(21, 42, 42, 21);
    queue_segment(63, 0, 0, 1);
    queue_segment(1, 63, 0, 0);
    // random segments: mostly full-range, some short, some aligned
    for (int i = 0; i < RandomCnt; i++) begin
      mode = $urandom_range(99);
      ax   = $urandom_range(63);
      ay   = $urandom_range(63);
      if (mode < 55) begin
        bx = $urandom_range(63);
        by = $urandom_range(63);
      end else if (mode < 85) begin
        bx = (ax + $urandom_range(14) - 7) & 63;
        by = (ay + $urandom_range(14) - 7) & 63;
      end else begin
        len = $urandom_range(63);
        case ($urandom_range(3))
          0: begin bx = len; by = ay; end
          1: begin bx = ax;  by = len; end
          2: begin bx = (ax + len) & 63; by = (ay + len) & 63; end
          default: begin bx = (ax + len) & 63; by = (ay - len) & 63; end
        endcase
      end
      queue_segment(ax, ay, bx, by);
    end

    wait (rst_ni);
    while (seg_taken < TotalCnt) @(posedge clk_i);
    while (pixel_q.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("PASS line_rasterizer_core");
    end else begin
      $display("FAIL line_rasterizer_core");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/lr_pkg.sv
rtl/core/lr_ctrl.sv
rtl/core/lr_datapath.sv
rtl/core/line_rasterizer_core.sv
verif/line_rasterizer_core_tb.sv
